// ===== src/spi_pkg.sv =====
// Package for the slot interval profiler: op codes, command and payload types,
// the slot table size and the state encoding of the executor.
// No dependencies.
package spi_pkg;

    // Size of the slot table and the width of a slot index.
    localparam int SLOTS   = 8;
    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Reset value of the late threshold register.
    localparam logic [15:0] LATE_THRESHOLD_RESET = 16'd40;

    // Input op codes.
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_END     = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_RDMAX   = 3'd3;
    localparam logic [2:0] OP_PERIOD  = 3'd4;
    localparam logic [2:0] OP_LATE    = 3'd5;
    localparam logic [2:0] OP_REBASE  = 3'd6;

    // Payload of one input item.
    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [15:0] timer_now;
    } t_in_item;

    // Payload of one result item.
    typedef struct packed {
        logic [15:0] interval;
        logic [31:0] late_total;
    } t_out_item;

    // Classified command kinds passed from the front end to the executor.
    typedef enum logic [2:0] {
        K_START,
        K_END,
        K_READ,
        K_RDMAX,
        K_PERIOD,
        K_LATE,
        K_REBASE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_IW-1:0] slot;
        logic [15:0]        timer_now;
    } t_cmd;

    // Status of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Status of the executor.
    typedef struct packed {
        logic rebasing;
        logic exec;
    } t_back_stat;

    // Executor states.
    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_REBASE = 2'b10
    } t_state;

endpackage

// ===== src/slot_interval_profiler.sv =====
// Slot interval profiler. Items enter through a queue-style port (push/full)
// and results leave through another (empty/pop). Each item passes a registered
// classifying front end and a two-entry command queue, then the executor
// carries out one command per cycle as a read-modify-write of the addressed
// slot, so sustained throughput is one item per cycle while no rebase runs and
// the result register is free. A rebase walks the slot table one slot per
// cycle through the executor's single table port and holds the executor until
// the walk ends. Start, end and rebase items and items with an unused op or an
// absent slot give no result.
// Depends on spi_pkg, spi_front, spi_cmd_queue and spi_exec.
module slot_interval_profiler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  spi_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output spi_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import spi_pkg::*;

    logic        r_late_threshold;
    logic [15:0] r_threshold;
    logic        q_push;
    logic        q_pop;
    t_cmd        front_cmd;
    t_cmd        q_cmd;
    t_q_stat     q_stat;
    t_back_stat  back_stat;

    // Late threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= LATE_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // Marks that the threshold has been written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_late_threshold <= 1'b0;
        end else if (i_cfg_we) begin
            r_late_threshold <= 1'b1;
        end
    end

    spi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_q_stat  (q_stat),
        .o_q_push  (q_push),
        .o_cmd     (front_cmd)
    );

    spi_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    spi_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_q_stat    (q_stat),
        .o_q_pop     (q_pop),
        .i_threshold (r_threshold),
        .pop         (pop),
        .empty       (empty),
        .o_out_item  (o_out_item),
        .o_stat      (back_stat)
    );

`ifndef NO_ASSERTIONS
    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("command queue overflow");

    // The executor never takes a command from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("command queue underflow");

    // No command is taken while a rebase is walking the table.
    a_rebase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.rebasing |-> !back_stat.exec)
        else $error("command executed during rebase");

    // A threshold write lands in the register on the next edge.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_late_threshold && (r_threshold == $past(i_cfg_wdata))))
        else $error("threshold write lost");
`endif

endmodule

// ===== src/spi_front.sv =====
// Front end of the slot interval profiler: accepts items, drops the ones
// that do nothing and classifies the rest into commands.
// Depends on spi_pkg.
module spi_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  spi_pkg::t_in_item i_in_item,
    input  spi_pkg::t_q_stat  i_q_stat,
    output logic              o_q_push,
    output spi_pkg::t_cmd     o_cmd
);
    import spi_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    logic  n_keep;
    t_kind n_kind;
    logic  slot_ok;
    logic  accept;

    // The holding register drains into the queue whenever the queue has room.
    assign o_q_push = r_valid && !i_q_stat.full;
    assign full     = r_valid && i_q_stat.full;
    assign accept   = push && !full;
    assign o_cmd    = r_cmd;

    // Slot ops address a slot that must exist in the table.
    assign slot_ok = 32'(i_in_item.slot) < 32'(SLOTS);

    // Classify the op; the unused code and slots off the table are dropped.
    always_comb begin
        n_kind = K_START;
        n_keep = 1'b0;
        unique case (i_in_item.op)
            OP_START: begin
                n_kind = K_START;
                n_keep = slot_ok;
            end
            OP_END: begin
                n_kind = K_END;
                n_keep = slot_ok;
            end
            OP_READ: begin
                n_kind = K_READ;
                n_keep = slot_ok;
            end
            OP_RDMAX: begin
                n_kind = K_RDMAX;
                n_keep = slot_ok;
            end
            OP_PERIOD: begin
                n_kind = K_PERIOD;
                n_keep = slot_ok;
            end
            OP_LATE: begin
                n_kind = K_LATE;
                n_keep = 1'b1;
            end
            OP_REBASE: begin
                n_kind = K_REBASE;
                n_keep = 1'b1;
            end
            default: begin
                n_kind = K_START;
                n_keep = 1'b0;
            end
        endcase
    end

    // Valid flag of the holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= n_keep;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    // Command payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind      <= n_kind;
            r_cmd.slot      <= SLOT_IW'(i_in_item.slot);
            r_cmd.timer_now <= i_in_item.timer_now;
        end
    end

endmodule

// ===== src/spi_cmd_queue.sv =====
// Two-entry command queue between the front end and the executor.
// Depends on spi_pkg.
module spi_cmd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spi_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output spi_pkg::t_cmd    o_cmd,
    output spi_pkg::t_q_stat o_stat
);
    import spi_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/spi_exec.sv =====
// Executor of the slot interval profiler: holds the slot table and the late
// counter, carries out commands and keeps the result register.
// Depends on spi_pkg.
module spi_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spi_pkg::t_cmd       i_cmd,
    input  spi_pkg::t_q_stat    i_q_stat,
    output logic                o_q_pop,
    input  logic [15:0]         i_threshold,
    input  logic                pop,
    output logic                empty,
    output spi_pkg::t_out_item  o_out_item,
    output spi_pkg::t_back_stat o_stat
);
    import spi_pkg::*;

    logic [15:0]        r_start [SLOTS];
    logic [15:0]        r_end   [SLOTS];
    logic [15:0]        r_max   [SLOTS];
    logic [31:0]        r_late_cnt;
    t_state             r_state;
    logic [SLOT_IW-1:0] r_walk;
    logic [15:0]        r_rebase_val;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [SLOT_IW-1:0] idx;
    logic [15:0]        cur_start;
    logic [15:0]        cur_end;
    logic [15:0]        cur_max;
    logic               has_result;
    logic               out_free;
    logic               go;
    logic [15:0]        n_start;
    logic [15:0]        n_end;
    logic [15:0]        n_max;
    logic [15:0]        diff;
    logic [15:0]        diff_base;
    logic               late_hit;
    t_out_item          n_out;

    // One table address per cycle: the walk index while rebasing, else the slot.
    assign idx       = (r_state == ST_REBASE) ? r_walk : i_cmd.slot;
    assign cur_start = r_start[idx];
    assign cur_end   = r_end[idx];
    assign cur_max   = r_max[idx];

    assign has_result = (i_cmd.kind == K_READ) || (i_cmd.kind == K_RDMAX) ||
                        (i_cmd.kind == K_PERIOD) || (i_cmd.kind == K_LATE);
    assign out_free   = !r_out_valid || pop;
    assign go         = (r_state == ST_RUN) && !i_q_stat.empty &&
                        (!has_result || out_free);
    assign o_q_pop    = go;

    assign empty       = !r_out_valid;
    assign o_out_item  = r_out;
    assign o_stat.rebasing = (r_state == ST_REBASE);
    assign o_stat.exec     = go;

    // The end and period ops measure from the start stamp or the old end stamp.
    assign diff_base = (i_cmd.kind == K_PERIOD) ? cur_end : cur_start;
    assign diff      = i_cmd.timer_now - diff_base;
    assign late_hit  = (i_cmd.kind == K_PERIOD) && (diff >= i_threshold);

    // Next values of the addressed slot and the result of the command.
    always_comb begin
        n_start = cur_start;
        n_end   = cur_end;
        n_max   = cur_max;
        n_out   = '0;
        unique case (i_cmd.kind)
            K_START: begin
                n_start = i_cmd.timer_now;
            end
            K_END: begin
                n_end = i_cmd.timer_now;
                n_max = (diff > cur_max) ? diff : cur_max;
            end
            K_READ: begin
                n_out.interval = cur_end - cur_start;
            end
            K_RDMAX: begin
                n_out.interval = cur_max;
                n_max          = '0;
            end
            K_PERIOD: begin
                n_start        = cur_end;
                n_end          = i_cmd.timer_now;
                n_max          = (diff > cur_max) ? diff : cur_max;
                n_out.interval = diff;
            end
            K_LATE: begin
                n_out.late_total = r_late_cnt;
            end
            K_REBASE: begin
                n_out = '0;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Sequencer: ordinary commands run in the run state, rebase walks the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_walk  <= '0;
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    if (go && (i_cmd.kind == K_REBASE)) begin
                        r_state <= ST_REBASE;
                        r_walk  <= '0;
                    end
                end
                ST_REBASE: begin
                    if (r_walk == SLOT_IW'(SLOTS - 1)) begin
                        r_state <= ST_RUN;
                    end
                    r_walk <= r_walk + 1'b1;
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // Amount subtracted during a rebase.
    always_ff @(posedge i_clk) begin
        if (go && (i_cmd.kind == K_REBASE)) begin
            r_rebase_val <= i_cmd.timer_now;
        end
    end

    // Slot table and late counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
                r_max[i]   <= '0;
            end
            r_late_cnt <= '0;
        end else if (r_state == ST_REBASE) begin
            r_start[idx] <= cur_start - r_rebase_val;
        end else if (go) begin
            r_start[idx] <= n_start;
            r_end[idx]   <= n_end;
            r_max[idx]   <= n_max;
            if (i_cmd.kind == K_LATE) begin
                r_late_cnt <= '0;
            end else if (late_hit) begin
                r_late_cnt <= r_late_cnt + 32'd1;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (go && has_result) begin
            r_out <= n_out;
        end
    end

endmodule
